@@ hw/rtl/assert_macros.svh @@
// Assertion helpers: clock is always named clock, reset is reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/ietp_pkg.sv @@
package ietp_pkg;

   // Parse phases
   localparam logic [3:0] PH_HEADER   = 4'd0;
   localparam logic [3:0] PH_UNKNOWN  = 4'd1;
   localparam logic [3:0] PH_V4       = 4'd2;
   localparam logic [3:0] PH_V6_OPEN  = 4'd3;
   localparam logic [3:0] PH_V6_START = 4'd4;
   localparam logic [3:0] PH_V6_LEAD  = 4'd5;
   localparam logic [3:0] PH_V6_DCOL  = 4'd6;
   localparam logic [3:0] PH_V6_GROUP = 4'd7;
   localparam logic [3:0] PH_V6_COLON = 4'd8;
   localparam logic [3:0] PH_V6_CLOSE = 4'd9;
   localparam logic [3:0] PH_PORT     = 4'd10;

   localparam logic [3:0] ZERO_NONE   = 4'd15;

   localparam logic [1:0] VER_NONE    = 2'd0;
   localparam logic [1:0] VER_V4      = 2'd1;
   localparam logic [1:0] VER_V6      = 2'd2;
   localparam logic [1:0] VER_PROV    = 2'd3;

   localparam logic [1:0] PROTO_NONE  = 2'd0;
   localparam logic [1:0] PROTO_TCP   = 2'd1;
   localparam logic [1:0] PROTO_UDP   = 2'd2;

   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_OPEN   = 8'h5B;
   localparam logic [7:0] CH_CLOSE  = 8'h5D;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } ietp_req_type;

   typedef struct packed {
      logic        status;
      logic [1:0]  ip_version;
      logic [1:0]  protocol;
      logic [31:0] ipv4_address;
      logic [63:0] ipv6_upper;
      logic [63:0] ipv6_lower;
      logic [15:0] port_number;
   } ietp_rsp_type;

   typedef struct packed {
      logic [3:0]       phase;
      logic [2:0]       hpos;
      logic [1:0]       ver;
      logic [1:0]       proto;
      logic [15:0]      acc;
      logic [2:0]       dcnt;
      logic [3:0]       fidx;
      logic [3:0]       zrun;
      logic [7:0][15:0] grp;
      logic [3:0][7:0]  oct;
      logic [15:0]      port;
      logic             err;
   } ietp_state_type;

   localparam ietp_state_type STATE_RESET = '{
      phase: PH_HEADER, hpos: 3'd0, ver: VER_NONE, proto: PROTO_NONE, acc: 16'd0,
      dcnt: 3'd0, fidx: 4'd0, zrun: ZERO_NONE, grp: '0, oct: '0, port: 16'd0,
      err: 1'b0};

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      if (c >= "0" && c <= "9") v = c - 8'h30;
      else if (c >= "a" && c <= "f") v = c - 8'h57;
      else v = c - 8'h37;
      return v[3:0];
   endfunction

   // Expanded IPv6 group i, with the zero run filled in
   function automatic logic [15:0] expand_group(input logic [7:0][15:0] grp,
                                                input logic [3:0] fidx,
                                                input logic [3:0] zrun,
                                                input logic [2:0] i);
      logic [3:0] parts;
      logic [4:0] zend;
      logic [2:0] src;
      parts = (fidx > 4'd8) ? 4'd8 : fidx;
      zend  = {1'b0, zrun} + 5'd8 - {1'b0, parts};
      src   = i + parts[2:0];
      if (zrun == ZERO_NONE || {1'b0, i} < zrun) return grp[i];
      else if ({2'b00, i} < zend) return 16'd0;
      else return grp[src];
   endfunction

endpackage

@@ hw/rtl/ip_endpoint_text_parser_top.sv @@
// channel | ports                          | word
// req     | req_valid, req_stall, req_word | one character and its last mark
// rsp     | rsp_valid, rsp_stall, rsp_word | parse result, one per text
// One character per cycle while req_stall is low; the result appears in the cycle after the last character is taken.
// The per-character parse state and the result register are the only stages.
// Reset clears the parse state and empties the result register.
// req_stall is high only while a result is held and rsp_stall is high.
module ip_endpoint_text_parser_top
   import ietp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ietp_req_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ietp_rsp_type rsp_word
);

`include "assert_macros.svh"

   ietp_state_type st_ff, st_in, st_step;
   ietp_rsp_type   rsp_word_ff, rsp_word_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;
   logic           ok;
   logic           hdone;
   logic [2:0]     gi;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   ietp_step u_step (.cur(st_ff), .c(req_word.char_code), .nxt(st_step));

   // Result from the updated state
   always_comb begin
      ok    = !st_step.err && (st_step.phase == PH_PORT || st_step.phase == PH_UNKNOWN);
      hdone = st_step.phase != PH_HEADER;
      gi    = 3'd0;
      rsp_word_in              = '0;
      rsp_word_in.status       = ~ok;
      rsp_word_in.ip_version   = ((hdone || st_step.hpos >= 3'd2) && st_step.ver != VER_PROV)
                                 ? st_step.ver : VER_NONE;
      rsp_word_in.protocol     = hdone ? st_step.proto : PROTO_NONE;
      if (ok && st_step.phase == PH_PORT) begin
         if (st_step.ver == VER_V4)
            rsp_word_in.ipv4_address = {st_step.oct[0], st_step.oct[1],
                                        st_step.oct[2], st_step.oct[3]};
         else
            for (int i = 0; i < 4; i++) begin
               gi = 3'(i);
               rsp_word_in.ipv6_upper[63-16*i -: 16] =
                  expand_group(st_step.grp, st_step.fidx, st_step.zrun, gi);
               rsp_word_in.ipv6_lower[63-16*i -: 16] =
                  expand_group(st_step.grp, st_step.fidx, st_step.zrun, gi + 3'd4);
            end
         rsp_word_in.port_number = st_step.port;
      end
   end

   // Next parse state: back to reset after each text
   always_comb begin
      st_in = st_ff;
      if (accept) st_in = req_word.last_char ? STATE_RESET : st_step;
   end

   assign rsp_valid_in = (accept & req_word.last_char) | req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_word.last_char) rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `ASSERT_NEXT(a_last_gives_word, accept && req_word.last_char, rsp_valid)
   `ASSERT_NEXT(a_last_resets, accept && req_word.last_char, st_ff.phase == PH_HEADER)
   `ASSERT_SAME(a_err_no_addr, rsp_valid && rsp_word.status,
                rsp_word.ipv4_address == 32'd0 && rsp_word.port_number == 16'd0)

endmodule

@@ hw/rtl/ietp_step.sv @@
module ietp_step
   import ietp_pkg::*;
(
   input  ietp_state_type cur,
   input  logic [7:0]     c,
   output ietp_state_type nxt
);

   logic       dec;
   logic       hex;
   logic [3:0] h;
   logic [3:0] d;
   logic [3:0] fidx_inc;
   logic [7:0] v4_sep;

   assign dec      = (c >= "0") && (c <= "9");
   assign hex      = is_hex(c);
   assign h        = hex_val(c);
   assign d        = hex_val(c);
   assign fidx_inc = cur.fidx + 4'd1;
   assign v4_sep   = (cur.fidx < 4'd3) ? CH_DOT : CH_COLON;

   // Per-character update
   always_comb begin
      nxt = cur;
      if (!cur.err) begin
         case (cur.phase)
            PH_HEADER: begin
               case (cur.hpos)
                  3'd0: nxt.ver = (c == "v") ? VER_PROV : VER_NONE;
                  3'd1: begin
                     if (cur.ver == VER_PROV && c == "4") nxt.ver = VER_V4;
                     else if (cur.ver == VER_PROV && c == "6") nxt.ver = VER_V6;
                     else nxt.ver = VER_NONE;
                  end
                  3'd2: nxt.proto = (c == "t") ? PROTO_TCP : (c == "u") ? PROTO_UDP : PROTO_NONE;
                  3'd3: begin
                     if (!((cur.proto == PROTO_TCP && c == "c") ||
                           (cur.proto == PROTO_UDP && c == "d")))
                        nxt.proto = PROTO_NONE;
                  end
                  default: begin
                     if (c != "p") nxt.proto = PROTO_NONE;
                     nxt.phase = (cur.ver == VER_V4) ? PH_V4 :
                                 (cur.ver == VER_V6) ? PH_V6_OPEN : PH_UNKNOWN;
                  end
               endcase
               if (cur.hpos < 3'd4) nxt.hpos = cur.hpos + 3'd1;
            end
            PH_UNKNOWN: ;
            PH_V4: begin
               if (c == v4_sep) begin
                  if (cur.dcnt == 3'd0) nxt.err = 1'b1;
                  else begin
                     nxt.oct[cur.fidx[1:0]] = cur.acc[7:0];
                     nxt.fidx = fidx_inc;
                     nxt.acc  = 16'd0;
                     nxt.dcnt = 3'd0;
                     if (fidx_inc >= 4'd4) nxt.phase = PH_PORT;
                  end
               end else if (dec && cur.dcnt < 3'd3) begin
                  nxt.acc  = (cur.acc << 3) + (cur.acc << 1) + {12'd0, d};
                  nxt.dcnt = cur.dcnt + 3'd1;
               end else nxt.err = 1'b1;
            end
            PH_V6_OPEN: begin
               if (c == CH_OPEN) nxt.phase = PH_V6_START; else nxt.err = 1'b1;
            end
            PH_V6_START, PH_V6_DCOL, PH_V6_COLON: begin
               if (cur.phase == PH_V6_START && c == CH_COLON) nxt.phase = PH_V6_LEAD;
               else if (cur.phase == PH_V6_DCOL && c == CH_CLOSE) nxt.phase = PH_V6_CLOSE;
               else if (cur.phase == PH_V6_COLON && c == CH_COLON && cur.zrun == ZERO_NONE) begin
                  nxt.zrun  = cur.fidx;
                  nxt.phase = PH_V6_DCOL;
               end else if (hex) begin
                  nxt.acc   = {12'd0, h};
                  nxt.dcnt  = 3'd1;
                  nxt.phase = PH_V6_GROUP;
               end else nxt.err = 1'b1;
            end
            PH_V6_LEAD: begin
               if (c == CH_COLON) begin
                  nxt.zrun  = 4'd0;
                  nxt.phase = PH_V6_DCOL;
               end else nxt.err = 1'b1;
            end
            PH_V6_GROUP: begin
               if (hex) begin
                  if (cur.dcnt >= 3'd4) nxt.err = 1'b1;
                  else begin
                     nxt.acc  = {cur.acc[11:0], h};
                     nxt.dcnt = cur.dcnt + 3'd1;
                  end
               end else if (c == CH_COLON || c == CH_CLOSE) begin
                  nxt.grp[cur.fidx[2:0]] = cur.acc;
                  nxt.fidx = fidx_inc;
                  nxt.acc  = 16'd0;
                  nxt.dcnt = 3'd0;
                  if (c == CH_COLON) begin
                     if (fidx_inc >= 4'd8) nxt.err = 1'b1;
                     else nxt.phase = PH_V6_COLON;
                  end else if ((cur.zrun != ZERO_NONE) ? (fidx_inc >= 4'd8)
                                                       : (fidx_inc != 4'd8))
                     nxt.err = 1'b1;
                  else nxt.phase = PH_V6_CLOSE;
               end else nxt.err = 1'b1;
            end
            PH_V6_CLOSE: begin
               if (c == CH_COLON) nxt.phase = PH_PORT; else nxt.err = 1'b1;
            end
            PH_PORT: begin
               if (dec) nxt.port = (cur.port << 3) + (cur.port << 1) + {12'd0, d};
               else nxt.err = 1'b1;
            end
            default: nxt.err = 1'b1;
         endcase
      end
   end

endmodule

@@ test/ip_endpoint_text_parser_top_test.sv @@
module ip_endpoint_text_parser_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ietp_pkg::*;

   // Parse results predicted from the characters seen so far
   class endpoint_scoreboard;
      logic [3:0]       phase;
      logic [2:0]       hpos;
      logic [1:0]       ver;
      logic [1:0]       proto;
      logic [15:0]      acc;
      logic [2:0]       dcnt;
      logic [3:0]       fidx;
      logic [3:0]       zrun;
      logic [15:0]      grp [8];
      logic [7:0]       oct [4];
      logic [15:0]      port;
      logic             err;
      ietp_rsp_type     pending_results [$];
      int               mismatches;
      int               results_checked;
      int               texts_ok;

      function new();
         clear_state();
         mismatches = 0;
         results_checked = 0;
         texts_ok = 0;
      endfunction

      function void clear_state();
         phase = PH_HEADER; hpos = 0; ver = VER_NONE; proto = PROTO_NONE;
         acc = 0; dcnt = 0; fidx = 0; zrun = ZERO_NONE; port = 0; err = 0;
         foreach (grp[i]) grp[i] = 0;
         foreach (oct[i]) oct[i] = 0;
      endfunction

      function int hex_digit(logic [7:0] c);
         if (c >= "0" && c <= "9") return c - "0";
         if (c >= "a" && c <= "f") return c - "a" + 10;
         if (c >= "A" && c <= "F") return c - "A" + 10;
         return -1;
      endfunction

      function void begin_group(int d);
         acc = d; dcnt = 1; phase = PH_V6_GROUP;
      endfunction

      function void close_group();
         grp[fidx[2:0]] = acc; fidx = fidx + 1; acc = 0; dcnt = 0;
      endfunction

      function void header_step(logic [7:0] c);
         case (hpos)
            0: ver = (c == "v") ? VER_PROV : VER_NONE;
            1: begin
               if (ver == VER_PROV && c == "4") ver = VER_V4;
               else if (ver == VER_PROV && c == "6") ver = VER_V6;
               else ver = VER_NONE;
            end
            2: proto = (c == "t") ? PROTO_TCP : (c == "u") ? PROTO_UDP : PROTO_NONE;
            3: begin
               if (!((proto == PROTO_TCP && c == "c") || (proto == PROTO_UDP && c == "d")))
                  proto = PROTO_NONE;
            end
            default: begin
               if (c != "p") proto = PROTO_NONE;
               phase = (ver == VER_V4) ? PH_V4 : (ver == VER_V6) ? PH_V6_OPEN : PH_UNKNOWN;
            end
         endcase
         if (hpos < 4) hpos = hpos + 1;
      endfunction

      function void char_step(logic [7:0] c);
         int h;
         bit dec;
         h = hex_digit(c);
         dec = (c >= "0" && c <= "9");
         case (phase)
            PH_HEADER: header_step(c);
            PH_UNKNOWN: ;
            PH_V4: begin
               if (c == ((fidx < 3) ? CH_DOT : CH_COLON)) begin
                  if (dcnt == 0) err = 1;
                  else begin
                     oct[fidx[1:0]] = acc[7:0]; fidx = fidx + 1; acc = 0; dcnt = 0;
                     if (fidx >= 4) phase = PH_PORT;
                  end
               end else if (dec && dcnt < 3) begin
                  acc = acc * 10 + (c - "0"); dcnt = dcnt + 1;
               end else err = 1;
            end
            PH_V6_OPEN: if (c == CH_OPEN) phase = PH_V6_START; else err = 1;
            PH_V6_START: begin
               if (c == CH_COLON) phase = PH_V6_LEAD;
               else if (h >= 0) begin_group(h);
               else err = 1;
            end
            PH_V6_LEAD: begin
               if (c == CH_COLON) begin
                  zrun = 0; phase = PH_V6_DCOL;
               end else err = 1;
            end
            PH_V6_DCOL: begin
               if (c == CH_CLOSE) phase = PH_V6_CLOSE;
               else if (h >= 0) begin_group(h);
               else err = 1;
            end
            PH_V6_GROUP: begin
               if (h >= 0) begin
                  if (dcnt >= 4) err = 1;
                  else begin
                     acc = {acc[11:0], 4'(h)}; dcnt = dcnt + 1;
                  end
               end else if (c == CH_COLON) begin
                  close_group();
                  if (fidx >= 8) err = 1; else phase = PH_V6_COLON;
               end else if (c == CH_CLOSE) begin
                  close_group();
                  if ((zrun != ZERO_NONE) ? (fidx >= 8) : (fidx != 8)) err = 1;
                  else phase = PH_V6_CLOSE;
               end else err = 1;
            end
            PH_V6_COLON: begin
               if (c == CH_COLON && zrun == ZERO_NONE) begin
                  zrun = fidx; phase = PH_V6_DCOL;
               end else if (h >= 0) begin_group(h);
               else err = 1;
            end
            PH_V6_CLOSE: if (c == CH_COLON) phase = PH_PORT; else err = 1;
            PH_PORT: begin
               if (dec) port = port * 10 + (c - "0"); else err = 1;
            end
            default: err = 1;
         endcase
      endfunction

      // Group i of the address with the zero run filled in
      function logic [15:0] full_group(int i);
         int parts;
         parts = (fidx > 8) ? 8 : fidx;
         if (zrun == ZERO_NONE || i < zrun) return grp[i];
         if (i < zrun + 8 - parts) return 16'd0;
         return grp[(i - (8 - parts)) & 7];
      endfunction

      function void note_char(ietp_req_type w);
         ietp_rsp_type r;
         bit ok, hdone;
         if (!err) char_step(w.char_code);
         if (!w.last_char) return;
         hdone = (phase != PH_HEADER);
         ok = !err && (phase == PH_PORT || phase == PH_UNKNOWN);
         r = '0;
         r.status = !ok;
         r.ip_version = ((hdone || hpos >= 2) && ver != VER_PROV) ? ver : VER_NONE;
         r.protocol = hdone ? proto : PROTO_NONE;
         if (ok && phase == PH_PORT) begin
            if (ver == VER_V4) r.ipv4_address = {oct[0], oct[1], oct[2], oct[3]};
            else begin
               for (int i = 0; i < 4; i++) begin
                  r.ipv6_upper = {r.ipv6_upper[47:0], full_group(i)};
                  r.ipv6_lower = {r.ipv6_lower[47:0], full_group(i + 4)};
               end
            end
            r.port_number = port;
         end
         if (ok) texts_ok++;
         pending_results.push_back(r);
         clear_state();
      endfunction

      function void check_result(ietp_rsp_type got);
         ietp_rsp_type e;
         results_checked++;
         if (pending_results.size() == 0) begin
            $error("unexpected result word %h", got);
            mismatches++;
            return;
         end
         e = pending_results.pop_front();
         if (got.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, got.status); mismatches++;
         end
         if (got.ip_version !== e.ip_version) begin
            $error("ip_version: expected %0d, got %0d", e.ip_version, got.ip_version);
            mismatches++;
         end
         if (got.protocol !== e.protocol) begin
            $error("protocol: expected %0d, got %0d", e.protocol, got.protocol); mismatches++;
         end
         if (got.ipv4_address !== e.ipv4_address) begin
            $error("ipv4_address: expected %h, got %h", e.ipv4_address, got.ipv4_address);
            mismatches++;
         end
         if (got.ipv6_upper !== e.ipv6_upper) begin
            $error("ipv6_upper: expected %h, got %h", e.ipv6_upper, got.ipv6_upper);
            mismatches++;
         end
         if (got.ipv6_lower !== e.ipv6_lower) begin
            $error("ipv6_lower: expected %h, got %h", e.ipv6_lower, got.ipv6_lower);
            mismatches++;
         end
         if (got.port_number !== e.port_number) begin
            $error("port_number: expected %0d, got %0d", e.port_number, got.port_number);
            mismatches++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   ietp_req_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   ietp_rsp_type rsp_word;

   endpoint_scoreboard board;
   int  cycle_count;
   int  words_sent;
   bit  hold_off_now;

   ip_endpoint_text_parser_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   always begin
      clock = 1'b0; #2;
      clock = 1'b1; #2;
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("ip_endpoint_text_parser_top verification failed");
         $finish;
      end
   end

   // Result side: sample accepted words and stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_word);
   end

   initial begin
      int gap;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_now) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            hold_off_now = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if ($urandom_range(0, 2) == 0) gap = 0;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   // Send one word; the idle draw is taken first. Valid stays up after
   // acceptance so the next word can follow at once.
   task automatic send_char(logic [7:0] c, bit last, bit no_idle = 0);
      int gap;
      gap = no_idle ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{char_code: c, last_char: last};
      do @(posedge clock); while (req_stall);
      board.note_char('{char_code: c, last_char: last});
      words_sent++;
   endtask

   task automatic send_text(string s, bit no_idle = 0);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1, no_idle);
   endtask

   task automatic wait_drained();
      while (board.pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic string hex_group();
      string s, d;
      int n, k;
      s = "";
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         d = "0123456789abcdefABCDEF";
         k = $urandom_range(0, 21);
         s = {s, d.substr(k, k)};
      end
      return s;
   endfunction

   function automatic string dec_str(int maxv);
      string s;
      s.itoa($urandom_range(0, maxv));
      return s;
   endfunction

   // Well-formed or slightly broken endpoint text
   function automatic string random_text();
      string s, hdr, body;
      int kind, ng, zpos;
      hdr = {($urandom_range(0, 9) == 0) ? "x" : "v",
             ($urandom_range(0, 1) == 0) ? "4" : "6"};
      hdr = {hdr, ($urandom_range(0, 9) == 0) ? "tqp" :
                  ($urandom_range(0, 1) == 0) ? "tcp" : "udp"};
      kind = $urandom_range(0, 9);
      if (hdr[1] == "4") begin
         body = {dec_str(($urandom_range(0, 3) == 0) ? 999 : 255), ".",
                 dec_str(255), ".", dec_str(255), ".", dec_str(999)};
      end else begin
         ng = $urandom_range(1, 8);
         zpos = (ng == 8 && $urandom_range(0, 3) != 0) ? -1 : $urandom_range(0, ng);
         body = "[";
         for (int i = 0; i < ng; i++) begin
            if (i == zpos) body = {body, "::"};
            else if (i > 0) body = {body, ":"};
            body = {body, hex_group()};
         end
         if (zpos == ng) body = {body, "::"};
         body = {body, "]"};
      end
      s = {hdr, body, ":", dec_str(($urandom_range(0, 3) == 0) ? 99999 : 65535)};
      if (kind == 0) s = s.substr(0, $urandom_range(0, s.len() - 1));
      else if (kind == 1) s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(0, 255));
      return s;
   endfunction

   initial begin
      string directed [$];
      string t;
      board = new();
      cycle_count = 0;
      words_sent = 0;
      hold_off_now = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed texts: extremes and each special case
      directed = '{"v4tcp0.0.0.0:0", "v4udp255.255.255.255:65535", "v4tcp999.1.2.3:70000",
                   "v6udp[ab::1]:53", "v6tcp[::]:1", "v6tcp[::1]:", "v6udp[1::]:2",
                   "v6tcp[FFFF:ffff:0:1:2:3:4:5]:9", "v6tcp[1:2:3:4:5:6:7:8::]:1",
                   "v6tcp[1::2::3]:1", "v6tcp[:1::2]:1", "v6tcp[1:]:1", "v6tcp[]:1",
                   "v6tcp[12345::1]:1", "v6udp[g::1]:1", "v7tcpanything", "v4xyz1.2.3.4:5",
                   "v4", "v", "v4tc", "v4tcp1..2.3:4", "v4tcp1.2.3.4:8a", "v4tcp1.2.3"};
      foreach (directed[i]) send_text(directed[i]);
      send_char(8'hFF, 1);
      send_char(8'h00, 1);

      // Sender waits until the block has drained
      req_valid <= 1'b0;
      wait_drained();

      // Receiver holds off while characters keep coming
      hold_off_now = 1;
      for (int i = 0; i < 6; i++) send_text("v4tcp1.2.3.4:5", 1);

      // Random texts
      while (words_sent < 800) begin
         t = random_text();
         if ($urandom_range(0, 19) == 0) begin
            for (int i = 0; i < 4; i++) send_char(8'($urandom_range(0, 255)), 0);
         end
         send_text(t);
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d characters, checked %0d results, %0d texts parsed cleanly.",
               words_sent, board.results_checked, board.texts_ok);
      $display("Covered IPv4, IPv6 with zero runs, unknown headers and malformed texts.");
      if (board.mismatches == 0 && board.pending_results.size() == 0)
         $display("ip_endpoint_text_parser_top verification clean");
      else
         $display("ip_endpoint_text_parser_top verification failed");
      $finish;
   end

endmodule
